// File: rtl/core/rrps_pkg.sv
`default_nettype none

package rrps_pkg;

  localparam int MAX_TASKS = 64;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int DATA_W    = 16;
  localparam int CLK_W     = 24;

  localparam logic [CNT_W-1:0]  TASK_LIMIT  = CNT_W'(MAX_TASKS);
  localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(MAX_TASKS - 1);
  localparam logic [CLK_W-1:0]  CLOCK_MAX   = {CLK_W{1'b1}};
  localparam logic [DATA_W-1:0] QUANTUM_RST = DATA_W'(4);

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_SLICE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_ADM1_GO,
    S_ADM1,
    S_MIN_GO,
    S_MIN,
    S_ADM2_GO,
    S_ADM2,
    S_HEAD,
    S_FETCH,
    S_EXEC,
    S_ADM3_GO,
    S_ADM3,
    S_PUSH,
    S_OUT
  } state_e;

  typedef struct packed {
    logic cap_in;
    logic res_clr;
    logic do_load;
    logic scan_start;
    logic scan_min;
    logic clk_jump;
    logic do_exec;
    logic do_push;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_busy;
    logic ring_empty;
    logic min_found;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/rrps_ctrl.sv
`default_nettype none

module rrps_ctrl
  import rrps_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  input  wire  in_kind_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  wire  out_stall_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_kind_i == KIND_LOAD) ? S_LOAD : S_ADM1_GO;
        end
      end
      S_LOAD:    state_d = S_OUT;
      S_ADM1_GO: state_d = S_ADM1;
      S_ADM1: begin
        if (!sts_i.scan_busy) begin
          state_d = sts_i.ring_empty ? S_MIN_GO : S_HEAD;
        end
      end
      S_MIN_GO:  state_d = S_MIN;
      S_MIN: begin
        if (!sts_i.scan_busy) begin
          state_d = sts_i.min_found ? S_ADM2_GO : S_OUT;
        end
      end
      S_ADM2_GO: state_d = S_ADM2;
      S_ADM2: begin
        if (!sts_i.scan_busy) begin
          state_d = sts_i.ring_empty ? S_OUT : S_HEAD;
        end
      end
      S_HEAD:    state_d = S_FETCH;
      S_FETCH:   state_d = S_EXEC;
      S_EXEC:    state_d = S_ADM3_GO;
      S_ADM3_GO: state_d = S_ADM3;
      S_ADM3: begin
        if (!sts_i.scan_busy) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH:    state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.cap_in   = in_valid_i;
        cmd_o.res_clr  = in_valid_i;
      end
      S_LOAD:    cmd_o.do_load = 1'b1;
      S_ADM1_GO: cmd_o.scan_start = 1'b1;
      S_MIN_GO: begin
        cmd_o.scan_start = 1'b1;
        cmd_o.scan_min   = 1'b1;
      end
      S_ADM2_GO: begin
        cmd_o.scan_start = 1'b1;
        cmd_o.clk_jump   = 1'b1;
      end
      S_EXEC:    cmd_o.do_exec = 1'b1;
      S_ADM3_GO: cmd_o.scan_start = 1'b1;
      S_PUSH:    cmd_o.do_push = 1'b1;
      S_OUT:     cmd_o.out_load = out_free;
      default:   cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/core/rrps_dp.sv
`default_nettype none

module rrps_dp
  import rrps_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [DATA_W-1:0]  cfg_data_i,
  input  wire  [DATA_W-1:0]  task_id_i,
  input  wire  [DATA_W-1:0]  arrival_i,
  input  wire  [DATA_W-1:0]  burst_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic               slice_valid_o,
  output logic [DATA_W-1:0]  slice_task_o,
  output logic [CLK_W-1:0]   slice_start_o,
  output logic [CLK_W-1:0]   slice_end_o,
  output logic               first_run_o,
  output logic               finished_o,
  output logic               all_done_o,
  output logic               load_overflow_o
);

  // Task table and ready ring
  logic [DATA_W-1:0] tid_mem  [MAX_TASKS];
  logic [DATA_W-1:0] arr_mem  [MAX_TASKS];
  logic [DATA_W-1:0] rem_mem  [MAX_TASKS];
  logic [IDX_W-1:0]  ring_mem [MAX_TASKS];

  logic [MAX_TASKS-1:0] started_q, queued_q;

  logic [DATA_W-1:0] quantum_q;
  logic [CNT_W-1:0]  loaded_q, active_q, ring_cnt_q;
  logic [IDX_W-1:0]  ring_head_q, ring_tail_q;
  logic [CLK_W-1:0]  clock_q;

  logic              scan_run_q, scan_min_q, chk_vld_q, min_found_q;
  logic [CNT_W-1:0]  scan_addr_q;
  logic [IDX_W-1:0]  chk_idx_q;
  logic [DATA_W-1:0] earliest_q;

  logic [DATA_W-1:0] in_tid_q, in_arr_q, in_burst_q;
  logic [DATA_W-1:0] tid_rd_q, arr_rd_q, rem_rd_q;
  logic [IDX_W-1:0]  ring_rd_q;
  logic [IDX_W-1:0]  cur_idx_q;
  logic [DATA_W-1:0] cur_rem_q;

  logic              res_valid_q, res_first_q, res_fin_q, res_ovf_q;
  logic [DATA_W-1:0] res_task_q;
  logic [CLK_W-1:0]  res_start_q, res_end_q;

  logic              out_valid_q, out_first_q, out_fin_q, out_done_q, out_ovf_q;
  logic [DATA_W-1:0] out_task_q;
  logic [CLK_W-1:0]  out_start_q, out_end_q;

  logic              issue, adm_hit, min_hit, push_en, load_ok;
  logic [IDX_W-1:0]  rd_addr, push_idx, load_idx;
  logic [DATA_W-1:0] q_eff, run_len, rem_new;
  logic [CLK_W:0]    end_sum;
  logic [CLK_W-1:0]  end_sat;

  assign load_ok  = loaded_q < TASK_LIMIT;
  assign load_idx = loaded_q[IDX_W-1:0];
  assign issue    = scan_run_q && (scan_addr_q < loaded_q);
  assign rd_addr  = scan_run_q ? scan_addr_q[IDX_W-1:0] : ring_rd_q;

  assign adm_hit = chk_vld_q && !scan_min_q && !queued_q[chk_idx_q] &&
                   (rem_rd_q != '0) && ({{(CLK_W-DATA_W){1'b0}}, arr_rd_q} <= clock_q);
  assign min_hit = chk_vld_q && scan_min_q && (rem_rd_q != '0) &&
                   (!min_found_q || (arr_rd_q < earliest_q));

  assign push_en  = (adm_hit || (cmd_i.do_push && (cur_rem_q != '0))) &&
                    (ring_cnt_q < TASK_LIMIT);
  assign push_idx = cmd_i.do_push ? cur_idx_q : chk_idx_q;

  // Slice length and end time, saturating the clock
  assign q_eff   = (quantum_q == '0) ? DATA_W'(1) : quantum_q;
  assign run_len = (rem_rd_q < q_eff) ? rem_rd_q : q_eff;
  assign rem_new = rem_rd_q - run_len;
  assign end_sum = {1'b0, clock_q} + (CLK_W+1)'(run_len);
  assign end_sat = end_sum[CLK_W] ? CLOCK_MAX : end_sum[CLK_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_load && load_ok) begin
      tid_mem[load_idx] <= in_tid_q;
      arr_mem[load_idx] <= in_arr_q;
    end
    if (cmd_i.do_load && load_ok) begin
      rem_mem[load_idx] <= in_burst_q;
    end else if (cmd_i.do_exec) begin
      rem_mem[ring_rd_q] <= rem_new;
    end
    if (push_en) begin
      ring_mem[ring_tail_q] <= push_idx;
    end
    tid_rd_q  <= tid_mem[rd_addr];
    arr_rd_q  <= arr_mem[rd_addr];
    rem_rd_q  <= rem_mem[rd_addr];
    ring_rd_q <= ring_mem[ring_head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q   <= QUANTUM_RST;
      loaded_q    <= '0;
      active_q    <= '0;
      ring_cnt_q  <= '0;
      ring_head_q <= '0;
      ring_tail_q <= '0;
      clock_q     <= '0;
      started_q   <= '0;
      queued_q    <= '0;
      scan_run_q  <= 1'b0;
      scan_min_q  <= 1'b0;
      scan_addr_q <= '0;
      chk_vld_q   <= 1'b0;
      min_found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        quantum_q <= cfg_data_i;
      end

      if (cmd_i.do_load && load_ok) begin
        loaded_q            <= loaded_q + CNT_W'(1);
        started_q[load_idx] <= 1'b0;
        queued_q[load_idx]  <= 1'b0;
        if (in_burst_q != '0) begin
          active_q <= active_q + CNT_W'(1);
        end
      end

      // Scan sweep: issue one table row per cycle and check it in the cycle after
      if (cmd_i.scan_start) begin
        scan_run_q  <= 1'b1;
        scan_min_q  <= cmd_i.scan_min;
        scan_addr_q <= '0;
        chk_vld_q   <= 1'b0;
        min_found_q <= 1'b0;
      end else begin
        if (issue) begin
          scan_addr_q <= scan_addr_q + CNT_W'(1);
          chk_vld_q   <= 1'b1;
        end else begin
          scan_run_q <= 1'b0;
          chk_vld_q  <= 1'b0;
        end
        if (min_hit) begin
          min_found_q <= 1'b1;
        end
      end

      if (adm_hit) begin
        queued_q[chk_idx_q] <= 1'b1;
      end

      if (cmd_i.clk_jump) begin
        clock_q <= {{(CLK_W-DATA_W){1'b0}}, earliest_q};
      end else if (cmd_i.do_exec) begin
        clock_q <= end_sat;
      end

      if (push_en) begin
        ring_tail_q <= (ring_tail_q == LAST_IDX) ? '0 : ring_tail_q + IDX_W'(1);
        ring_cnt_q  <= ring_cnt_q + CNT_W'(1);
      end else if (cmd_i.do_exec) begin
        ring_head_q <= (ring_head_q == LAST_IDX) ? '0 : ring_head_q + IDX_W'(1);
        ring_cnt_q  <= ring_cnt_q - CNT_W'(1);
      end

      if (cmd_i.do_exec) begin
        started_q[ring_rd_q] <= 1'b1;
        if ((rem_rd_q != '0) && (rem_new == '0)) begin
          active_q <= active_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      in_tid_q   <= task_id_i;
      in_arr_q   <= arrival_i;
      in_burst_q <= burst_i;
    end
    if (issue) begin
      chk_idx_q <= scan_addr_q[IDX_W-1:0];
    end
    if (!cmd_i.scan_start && min_hit) begin
      earliest_q <= arr_rd_q;
    end

    if (cmd_i.res_clr) begin
      res_valid_q <= 1'b0;
      res_task_q  <= '0;
      res_start_q <= '0;
      res_end_q   <= '0;
      res_first_q <= 1'b0;
      res_fin_q   <= 1'b0;
      res_ovf_q   <= 1'b0;
    end else if (cmd_i.do_load) begin
      res_ovf_q <= !load_ok;
    end else if (cmd_i.do_exec) begin
      res_valid_q <= 1'b1;
      res_task_q  <= tid_rd_q;
      res_start_q <= clock_q;
      res_end_q   <= end_sat;
      res_first_q <= !started_q[ring_rd_q];
      res_fin_q   <= (rem_new == '0);
      cur_idx_q   <= ring_rd_q;
      cur_rem_q   <= rem_new;
    end

    if (cmd_i.out_load) begin
      out_valid_q <= res_valid_q;
      out_task_q  <= res_task_q;
      out_start_q <= res_start_q;
      out_end_q   <= res_end_q;
      out_first_q <= res_first_q;
      out_fin_q   <= res_fin_q;
      out_done_q  <= (active_q == '0);
      out_ovf_q   <= res_ovf_q;
    end
  end

  assign sts_o.scan_busy  = scan_run_q || chk_vld_q;
  assign sts_o.ring_empty = (ring_cnt_q == '0);
  assign sts_o.min_found  = min_found_q;

  assign slice_valid_o   = out_valid_q;
  assign slice_task_o    = out_task_q;
  assign slice_start_o   = out_start_q;
  assign slice_end_o     = out_end_q;
  assign first_run_o     = out_first_q;
  assign finished_o      = out_fin_q;
  assign all_done_o      = out_done_q;
  assign load_overflow_o = out_ovf_q;

endmodule

`default_nettype wire

// File: rtl/core/round_robin_process_scheduler.sv
// Round-robin time-slice scheduler.
// Input channel (in_valid_i / in_stall_o): one item per transfer. kind_i low loads one
//   task (task_id_i, arrival_i, burst_i) into the next free table row; kind_i high runs
//   one slice of the head task of the ready ring for at most the programmed quantum.
// Output channel (out_valid_o / out_stall_i): exactly one result transfer per item.
// Configuration: cfg_we_i writes cfg_data_i into the quantum register (reset value 4,
//   zero acts as one). Write it only while the block is idle.
// Sequence: a load passes S_LOAD, then S_OUT registers its result onto out_valid_o.
//   A slice sweeps to admit arrivals, runs the ring head, sweeps again and pushes it
//   back if work is left. An empty ring first adds a sweep for the earliest pending
//   arrival; if one is found the clock jumps to it and a readmit sweep follows.
//   Every sweep walks the task table one row per cycle through a single read port,
//   and that sweep sets the throughput: one item at a time, in_stall_o high while busy.
// Results sit in an output register: the next item is taken while a result still
//   waits, and the finished result of that item holds in the datapath until the
//   receiver drains the register. A stalled result holds its value.
// Reset: the table is empty, the ring is empty, the clock is zero, the quantum is 4,
//   and no result is pending. Table contents come up undefined and are never read
//   before a load writes them.
`default_nettype none

module round_robin_process_scheduler
  import rrps_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [DATA_W-1:0]  cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire                kind_i,
  input  wire  [DATA_W-1:0]  task_id_i,
  input  wire  [DATA_W-1:0]  arrival_i,
  input  wire  [DATA_W-1:0]  burst_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic               slice_valid_o,
  output logic [DATA_W-1:0]  slice_task_o,
  output logic [CLK_W-1:0]   slice_start_o,
  output logic [CLK_W-1:0]   slice_end_o,
  output logic               first_run_o,
  output logic               finished_o,
  output logic               all_done_o,
  output logic               load_overflow_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequence load, admit sweeps, earliest-arrival sweep, slice and result transfer
  rrps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (kind_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Hold the task table, ready ring, scheduler clock and result registers
  rrps_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .task_id_i       (task_id_i),
    .arrival_i       (arrival_i),
    .burst_i         (burst_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .slice_valid_o   (slice_valid_o),
    .slice_task_o    (slice_task_o),
    .slice_start_o   (slice_start_o),
    .slice_end_o     (slice_end_o),
    .first_run_o     (first_run_o),
    .finished_o      (finished_o),
    .all_done_o      (all_done_o),
    .load_overflow_o (load_overflow_o)
  );

endmodule

`default_nettype wire

// File: dv/tb_round_robin_process_scheduler.sv
`timescale 1ns / 100ps

module tb_round_robin_process_scheduler;
  import rrps_pkg::*;

  // One input item as it crosses the input channel.
  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] task_id;
    logic [DATA_W-1:0] arrival;
    logic [DATA_W-1:0] burst;
  } sched_item_t;

  // One scheduler report as it crosses the output channel.
  typedef struct packed {
    logic              slice_valid;
    logic [DATA_W-1:0] slice_task;
    logic [CLK_W-1:0]  slice_start;
    logic [CLK_W-1:0]  slice_end;
    logic              first_run;
    logic              finished;
    logic              all_done;
    logic              load_overflow;
  } sched_report_t;

  // Block inputs start at known values.
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [DATA_W-1:0] cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              kind_i      = KIND_LOAD;
  logic [DATA_W-1:0] task_id_i   = '0;
  logic [DATA_W-1:0] arrival_i   = '0;
  logic [DATA_W-1:0] burst_i     = '0;
  logic              out_stall_i = 1'b0;

  logic              in_stall_o;
  logic              out_valid_o;
  logic              slice_valid_o;
  logic [DATA_W-1:0] slice_task_o;
  logic [CLK_W-1:0]  slice_start_o;
  logic [CLK_W-1:0]  slice_end_o;
  logic              first_run_o;
  logic              finished_o;
  logic              all_done_o;
  logic              load_overflow_o;

  round_robin_process_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .task_id_i       (task_id_i),
    .arrival_i       (arrival_i),
    .burst_i         (burst_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .slice_valid_o   (slice_valid_o),
    .slice_task_o    (slice_task_o),
    .slice_start_o   (slice_start_o),
    .slice_end_o     (slice_end_o),
    .first_run_o     (first_run_o),
    .finished_o      (finished_o),
    .all_done_o      (all_done_o),
    .load_overflow_o (load_overflow_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Scheduler shadow: task table, ready ring, clock and quantum as the block
  // should hold them after every accepted item.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] tbl_id      [MAX_TASKS];
  logic [DATA_W-1:0] tbl_arrival [MAX_TASKS];
  logic [DATA_W-1:0] tbl_left    [MAX_TASKS];
  bit                tbl_started [MAX_TASKS];
  bit                tbl_queued  [MAX_TASKS];
  logic [IDX_W-1:0]  ready_slots [MAX_TASKS];
  int unsigned       ready_head;
  int unsigned       ready_tail;
  int unsigned       ready_count;
  int unsigned       sched_clock;
  int unsigned       tasks_loaded;
  logic [DATA_W-1:0] quantum_shadow;

  sched_report_t     report_q[$];
  sched_item_t       item_q[$];

  int                n_queued    = 0;
  int                n_accepted  = 0;
  int                loads_issued = 0;
  int                errors      = 0;

  // Traffic shaping knobs, set per phase by the sequencer.
  int                idle_pct    = 0;
  int                stall_pct   = 0;
  bit                calm        = 1'b0;
  int                gap_left    = 0;
  int                stall_left  = 0;
  bit                in_took     = 1'b0;

  function automatic void ring_append(input int unsigned slot);
    if (ready_count < MAX_TASKS) begin
      ready_slots[ready_tail] = IDX_W'(slot);
      ready_tail = (ready_tail + 1) % MAX_TASKS;
      ready_count++;
    end
  endfunction

  // Queue every loaded task that has arrived, has work left and was never
  // queued, walking the table in load order.
  function automatic void admit_arrived();
    int unsigned i;
    for (i = 0; i < tasks_loaded; i++) begin
      if (!tbl_queued[i] && tbl_left[i] != 0 && tbl_arrival[i] <= sched_clock) begin
        tbl_queued[i] = 1'b1;
        ring_append(i);
      end
    end
  endfunction

  function automatic logic table_idle();
    int unsigned i;
    for (i = 0; i < tasks_loaded; i++)
      if (tbl_left[i] != 0)
        return 1'b0;
    return 1'b1;
  endfunction

  function automatic sched_report_t compute_report(input sched_item_t it);
    sched_report_t r;
    int unsigned   slot;
    int unsigned   qv;
    int unsigned   run;
    int unsigned   t_end;
    int unsigned   earliest;
    int unsigned   i;
    bit            found;
    r = '0;

    if (it.kind == KIND_LOAD) begin
      // A full table refuses the load and flags it.
      if (tasks_loaded < MAX_TASKS) begin
        tbl_id[tasks_loaded]      = it.task_id;
        tbl_arrival[tasks_loaded] = it.arrival;
        tbl_left[tasks_loaded]    = it.burst;
        tbl_started[tasks_loaded] = 1'b0;
        tbl_queued[tasks_loaded]  = 1'b0;
        tasks_loaded++;
      end else begin
        r.load_overflow = 1'b1;
      end
      r.all_done = table_idle();
      return r;
    end

    admit_arrived();
    if (ready_count == 0) begin
      // Empty ring: jump the clock to the earliest pending arrival.
      found    = 1'b0;
      earliest = 0;
      for (i = 0; i < tasks_loaded; i++) begin
        if (tbl_left[i] != 0 && (!found || tbl_arrival[i] < earliest)) begin
          earliest = tbl_arrival[i];
          found    = 1'b1;
        end
      end
      if (!found) begin
        r.all_done = 1'b1;
        return r;
      end
      sched_clock = earliest;
      admit_arrived();
      if (ready_count == 0) begin
        r.all_done = table_idle();
        return r;
      end
    end

    slot = ready_slots[ready_head];
    qv   = (quantum_shadow == 0) ? 1 : quantum_shadow;
    run  = (tbl_left[slot] < qv) ? tbl_left[slot] : qv;
    ready_head = (ready_head + 1) % MAX_TASKS;
    ready_count--;

    // The clock saturates, the remaining time still drops by the full slice.
    t_end = sched_clock + run;
    if (t_end > CLOCK_MAX)
      t_end = CLOCK_MAX;

    r.slice_valid = 1'b1;
    r.slice_task  = tbl_id[slot];
    r.slice_start = CLK_W'(sched_clock);
    r.slice_end   = CLK_W'(t_end);
    r.first_run   = !tbl_started[slot];

    tbl_left[slot]    = DATA_W'(tbl_left[slot] - run);
    tbl_started[slot] = 1'b1;
    sched_clock       = t_end;

    // Arrivals during the slice go ahead of the rotated task.
    admit_arrived();
    if (tbl_left[slot] != 0)
      ring_append(slot);

    r.finished = (tbl_left[slot] == 0);
    r.all_done = table_idle();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: present the next pending item at the falling edge, hold it
  // until a transfer, and insert random idle bursts between items.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_took)) begin
      // hold the current item until it transfers
    end else if (gap_left != 0) begin
      gap_left--;
      in_valid_i <= 1'b0;
    end else if (!calm && $urandom_range(99) < idle_pct) begin
      gap_left = $urandom_range(16);
      in_valid_i <= 1'b0;
    end else if (item_q.size() != 0) begin
      {kind_i, task_id_i, arrival_i, burst_i} <= item_q.pop_front();
      in_valid_i <= 1'b1;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Output sink: stall in random bursts.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(16);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic compare_field(input string name, input logic [CLK_W-1:0] want,
                               input logic [CLK_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest expected report,
  // then predict the report of any input transfer at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    sched_report_t want;
    in_took = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (report_q.size() == 0) begin
          $error("result transfer with no report expected");
          errors++;
        end else begin
          want = report_q.pop_front();
          compare_field("slice_valid", CLK_W'(want.slice_valid), CLK_W'(slice_valid_o));
          compare_field("slice_task", CLK_W'(want.slice_task), CLK_W'(slice_task_o));
          compare_field("slice_start", want.slice_start, slice_start_o);
          compare_field("slice_end", want.slice_end, slice_end_o);
          compare_field("first_run", CLK_W'(want.first_run), CLK_W'(first_run_o));
          compare_field("finished", CLK_W'(want.finished), CLK_W'(finished_o));
          compare_field("all_done", CLK_W'(want.all_done), CLK_W'(all_done_o));
          compare_field("load_overflow", CLK_W'(want.load_overflow),
                        CLK_W'(load_overflow_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        in_took = 1'b1;
        n_accepted++;
        report_q.push_back(compute_report({kind_i, task_id_i, arrival_i, burst_i}));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_item(input logic kind, input logic [DATA_W-1:0] id,
                            input logic [DATA_W-1:0] arr, input logic [DATA_W-1:0] bst);
    if (kind == KIND_LOAD)
      loads_issued++;
    item_q.push_back('{kind: kind, task_id: id, arrival: arr, burst: bst});
    n_queued++;
  endtask

  // Wait until every queued item transferred and every report came back.
  task automatic wait_drained();
    while (n_accepted != n_queued || report_q.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Write the quantum while the block is idle.
  task automatic set_quantum(input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    quantum_shadow = value;
  endtask

  // Mostly slices, with loads shaped to arrive around the running clock so
  // that jumps, arrivals during slices and rotation all get exercised. Once
  // the table is full every load is pure noise and must be refused.
  task automatic random_phase(input int n_items, input int load_pct, input bit wide);
    int unsigned       base;
    int unsigned       roll;
    int                k;
    logic [DATA_W-1:0] arr;
    logic [DATA_W-1:0] bst;
    base = (sched_clock > 65535) ? 65535 : sched_clock;
    for (k = 0; k < n_items; k++) begin
      arr = DATA_W'($urandom);
      bst = DATA_W'($urandom);
      if ($urandom_range(99) < load_pct) begin
        if (loads_issued < MAX_TASKS) begin
          roll = $urandom_range(99);
          if (roll < 10)
            arr = '0;
          else if (wide && roll < 40)
            arr = (roll < 20) ? 16'hFFFF : DATA_W'($urandom_range(65535));
          else
            arr = (base + $urandom_range(40) > 65535) ? 16'hFFFF
                                                      : DATA_W'(base + $urandom_range(40));
          roll = $urandom_range(99);
          if (roll < 8)
            bst = '0;
          else if (wide && roll < 20)
            bst = (roll < 14) ? 16'hFFFF : DATA_W'($urandom_range(65535));
          else if (roll < 30)
            bst = DATA_W'($urandom_range(300, 41));
          else
            bst = DATA_W'($urandom_range(40, 1));
        end
        queue_item(KIND_LOAD, DATA_W'($urandom), arr, bst);
      end else begin
        base += $urandom_range(5);
        queue_item(KIND_SLICE, DATA_W'($urandom), arr, bst);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    ready_head     = 0;
    ready_tail     = 0;
    ready_count    = 0;
    sched_clock    = 0;
    tasks_loaded   = 0;
    quantum_shadow = QUANTUM_RST;
    foreach (tbl_started[i]) begin
      tbl_started[i] = 1'b0;
      tbl_queued[i]  = 1'b0;
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset quantum of 4: nothing loaded, a zero-burst
    // task, a clock jump, arrivals during a slice, rotation, finish and a load
    // whose arrival has already passed.
    idle_pct  = 20;
    stall_pct = 20;
    queue_item(KIND_SLICE, 16'h0000, 16'h0000, 16'h0000);
    queue_item(KIND_LOAD,  16'h0000, 16'h0000, 16'h0000);
    queue_item(KIND_SLICE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_item(KIND_LOAD,  16'hFFFF, 16'd3,    16'd1);
    queue_item(KIND_SLICE, 16'h0000, 16'h0000, 16'h0000);
    queue_item(KIND_LOAD,  16'h1234, 16'd0,    16'd9);
    queue_item(KIND_LOAD,  16'h00FF, 16'd6,    16'd5);
    queue_item(KIND_LOAD,  16'h8000, 16'd40,   16'd2);
    repeat (6) queue_item(KIND_SLICE, 16'h0000, 16'h0000, 16'h0000);
    queue_item(KIND_SLICE, 16'h0000, 16'h0000, 16'h0000);
    queue_item(KIND_LOAD,  16'h5555, 16'd0,    16'd7);
    queue_item(KIND_SLICE, 16'hAAAA, 16'h5555, 16'hAAAA);
    repeat (2) queue_item(KIND_SLICE, 16'h0000, 16'h0000, 16'h0000);
    wait_drained();

    // Smallest quantum.
    set_quantum(16'd1);
    idle_pct  = 25;
    stall_pct = 25;
    random_phase(200, 8, 1'b0);
    wait_drained();

    // Zero quantum acts as one.
    set_quantum(16'd0);
    idle_pct  = 5;
    stall_pct = 40;
    random_phase(150, 7, 1'b0);
    wait_drained();

    set_quantum(DATA_W'($urandom_range(9, 2)));
    idle_pct  = 40;
    stall_pct = 5;
    random_phase(250, 8, 1'b0);
    wait_drained();

    // Largest quantum: huge bursts finish in a single slice, far arrivals.
    set_quantum(16'hFFFF);
    idle_pct  = 15;
    stall_pct = 15;
    random_phase(150, 8, 1'b1);
    wait_drained();

    // Last stretch runs without idling on either side and fills the table.
    set_quantum(DATA_W'($urandom_range(16, 1)));
    calm = 1'b1;
    random_phase(150, 20, 1'b1);
    wait_drained();

    // Catch any stray result after the last report.
    repeat (300) @(posedge clk_i);
    if (errors == 0 && report_q.size() == 0) begin
      $display("tb_round_robin_process_scheduler: done, clean");
    end else begin
      $display("tb_round_robin_process_scheduler: done, errors");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #12_000_000;
    $display("tb_round_robin_process_scheduler: done, errors");
    $finish;
  end

endmodule

// File: round_robin_process_scheduler.f
rtl/core/rrps_pkg.sv
rtl/core/rrps_ctrl.sv
rtl/core/rrps_dp.sv
rtl/core/round_robin_process_scheduler.sv
dv/tb_round_robin_process_scheduler.sv
